// ===== rtl/core/cda_pkg.sv =====
// shared types, constants and calendar helpers for the date arithmetic block
// no dependencies; imported by cda_serial, the top level and the checker
package cda_pkg;

  localparam int unsigned DEF_YEAR_BITS  = 16;
  localparam int unsigned DEF_COUNT_BITS = 20;

  // day serials of dates up to year 16383 fit in this many bits
  localparam int unsigned SER_W  = 23;
  localparam int unsigned DIST_W = 22;

  localparam logic [17:0] DAYS_400Y = 18'd146097;
  localparam logic [15:0] DAYS_100Y = 16'd36524;
  localparam logic [10:0] DAYS_4Y   = 11'd1461;
  localparam logic [8:0]  DAYS_1Y   = 9'd365;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_DIST = 2'd1,
    OP_CMP  = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SER_LD,
    S_SER_RD,
    S_CMP,
    S_Q400,
    S_Q100,
    S_Q4,
    S_Q1,
    S_MON,
    S_YEAR,
    S_DONE
  } state_e;

  // x / 100 by reciprocal, exact for 14-bit x
  function automatic logic [7:0] div100(input logic [13:0] x);
    logic [26:0] prod;
    prod = 27'(x) * 27'd5243;
    return prod[26:19];
  endfunction

  function automatic logic is_leap(input logic [13:0] y);
    logic [7:0]  q;
    logic [13:0] r;
    q = div100(y);
    r = y - 14'(14'(q) * 14'd100);
    return ((y[1:0] == 2'd0) && (r != 14'd0)) || ((r == 14'd0) && (q[1:0] == 2'd0));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m) inside
      4'd2:                                    len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:                 len = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      default:                                 len = 5'd0;
    endcase
    return len;
  endfunction

  // days before the month in a common year
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] n;
    case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  function automatic logic date_ok(input logic [4:0] d, input logic [3:0] m,
                                   input logic [13:0] y);
    return (m >= 4'd1) && (m <= 4'd12) && (y != 14'd0) && (d != 5'd0) &&
           (d <= month_len(m, is_leap(y)));
  endfunction

endpackage

// ===== rtl/core/cda_serial.sv =====
// converter from a checked date to its day serial since 0001-01-01
// uses cda_pkg helpers for the /100 reciprocal, leap rule and month offsets
module cda_serial
  import cda_pkg::*;
(
  input  logic             clk_i,
  input  logic             load_i,
  input  logic [4:0]       day_i,
  input  logic [3:0]       month_i,
  input  logic [13:0]      year_i,
  output logic [SER_W-1:0] serial_o
);

  logic [13:0] p_d, p_q;
  logic [7:0]  c_d, c_q;
  logic [8:0]  cum_d, cum_q;
  logic [4:0]  day_q;

  always_comb begin
    p_d   = year_i - 14'd1;
    c_d   = div100(p_d);
    cum_d = cum_days(month_i) + ((is_leap(year_i) && (month_i > 4'd2)) ? 9'd1 : 9'd0);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      p_q   <= p_d;
      c_q   <= c_d;
      cum_q <= cum_d;
      day_q <= day_i;
    end
  end

  // 365p + p/4 - p/100 + p/400 + month offset + day - 1
  assign serial_o = SER_W'(p_q) * SER_W'(365) + SER_W'(p_q[13:2]) - SER_W'(c_q)
                  + SER_W'(c_q[7:2]) + SER_W'(cum_q) + SER_W'(day_q) - SER_W'(1);

endmodule

// ===== rtl/core/calendar_date_add_and_difference_top.sv =====
// Gregorian date arithmetic: add a day count to a date, day distance between two
// dates, or an earlier-than compare. One item is worked at a time by a small
// sequencer around one shared compare-subtract unit; s_axis_tready_o is high only
// while the sequencer is idle. Compare and distance convert both dates to day
// serials and subtract them; an invalid date skips straight to the result. Add
// converts the date to a day serial and back, peeling 400-year blocks one quotient
// bit per cycle (max(COUNT_BITS,23)-16 steps), then up to 3 centuries, 5 four-year
// bits, up to 3 years and up to 11 months, one per cycle. A finished result
// waits in an output register, so the next beat is taken while it is unread.
// Depends on cda_pkg and cda_serial.
module calendar_date_add_and_difference_top
  import cda_pkg::*;
#(
  parameter  int unsigned YEAR_BITS  = DEF_YEAR_BITS,
  parameter  int unsigned COUNT_BITS = DEF_COUNT_BITS,
  localparam int unsigned IN_W       = ((46 + COUNT_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W      = ((32 + YEAR_BITS + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // first_day, first_month, first_year, second_day, second_month, second_year,
  // day_count
  input  logic [IN_W-1:0]  s_axis_tdata_i,
  // operation
  input  logic [1:0]       s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // out_day, out_month, out_year, distance, earlier
  output logic [OUT_W-1:0] m_axis_tdata_o,
  // input_invalid
  output logic             m_axis_tuser_o
);

  localparam int unsigned NB     = ((COUNT_BITS > SER_W) ? COUNT_BITS : SER_W) + 1;
  localparam int unsigned Q400B  = NB - 17;
  localparam int unsigned STEP_W = $clog2(Q400B);
  localparam int unsigned YW     = NB - 7;
  localparam int unsigned CW     = ((YW > YEAR_BITS) ? YW : YEAR_BITS) + 1;
  localparam logic [CW-1:0] YMAX = CW'((64'd1 << YEAR_BITS) - 64'd1);

  state_e state_q, state_d;

  op_e                   op_q;
  logic [4:0]            d1_q, d2_q;
  logic [3:0]            m1_q, m2_q;
  logic [13:0]           y1_q, y2_q;
  logic [COUNT_BITS-1:0] cnt_q;

  logic                  sel_q, sel_d;
  logic [SER_W-1:0]      ser_a_q, ser_a_d;
  logic [NB-1:0]         acc_q, acc_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [Q400B-1:0]      q400_q, q400_d;
  logic [1:0]            q100_q, q100_d;
  logic [4:0]            q4_q, q4_d;
  logic [1:0]            q1_q, q1_d;
  logic [3:0]            mon_q, mon_d;

  logic [4:0]            r_day_q, r_day_d;
  logic [3:0]            r_mon_q, r_mon_d;
  logic [YEAR_BITS-1:0]  r_year_q, r_year_d;
  logic [DIST_W-1:0]     r_dist_q, r_dist_d;
  logic                  r_earl_q, r_earl_d;
  logic                  r_inv_q, r_inv_d;

  logic                  o_valid_q, o_valid_d;
  logic [4:0]            o_day_q, o_day_d;
  logic [3:0]            o_mon_q, o_mon_d;
  logic [YEAR_BITS-1:0]  o_year_q, o_year_d;
  logic [DIST_W-1:0]     o_dist_q, o_dist_d;
  logic                  o_earl_q, o_earl_d;
  logic                  o_inv_q, o_inv_d;

  logic                  in_beat;
  logic                  chk_bad;
  logic                  ser_load;
  logic [SER_W-1:0]      ser;
  logic [NB-1:0]         sub_op;
  logic [NB:0]           diff;
  logic                  borrow;
  logic                  leap_sum;
  logic [4:0]            mlen;
  logic [YW-1:0]         year_full;
  logic [CW-1:0]         year_ext;
  logic                  out_free;

  assign in_beat  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !o_valid_q || m_axis_tready_i;
  assign ser_load = (state_q == S_SER_LD);

  always_comb begin
    case (op_q)
      OP_ADD:          chk_bad = !date_ok(d1_q, m1_q, y1_q);
      OP_DIST, OP_CMP: chk_bad = !(date_ok(d1_q, m1_q, y1_q) && date_ok(d2_q, m2_q, y2_q));
      default:         chk_bad = 1'b1;
    endcase
  end

  cda_serial u_serial (
    .clk_i    (clk_i),
    .load_i   (ser_load),
    .day_i    (sel_q ? d2_q : d1_q),
    .month_i  (sel_q ? m2_q : m1_q),
    .year_i   (sel_q ? y2_q : y1_q),
    .serial_o (ser)
  );

  // shared compare-subtract unit
  assign diff   = {1'b0, acc_q} - {1'b0, sub_op};
  assign borrow = diff[NB];

  // leap rule of the year being rebuilt from the block quotients
  assign leap_sum = (q1_q == 2'd3) && ((q4_q != 5'd24) || (q100_q == 2'd3));
  assign mlen     = month_len(mon_q, leap_sum);

  assign year_full = YW'(q400_q) * YW'(400) + YW'(q100_q) * YW'(100)
                   + YW'({q4_q, 2'b00}) + YW'(q1_q) + YW'(1);
  assign year_ext  = CW'(year_full);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (s_axis_tvalid_i) state_d = S_CHECK;
      S_CHECK:  state_d = chk_bad ? S_DONE : S_SER_LD;
      S_SER_LD: state_d = S_SER_RD;
      S_SER_RD: begin
        if (sel_q) state_d = S_CMP;
        else if (op_q == OP_ADD) state_d = S_Q400;
        else state_d = S_SER_LD;
      end
      S_CMP:    state_d = S_DONE;
      S_Q400:   if (step_q == '0) state_d = S_Q100;
      S_Q100:   if (borrow || (q100_q == 2'd3)) state_d = S_Q4;
      S_Q4:     if (step_q == '0) state_d = S_Q1;
      S_Q1:     if (borrow || (q1_q == 2'd3)) state_d = S_MON;
      S_MON:    if (borrow || (mon_q == 4'd12)) state_d = S_YEAR;
      S_YEAR:   state_d = S_DONE;
      S_DONE:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    s_axis_tready_o = (state_q == S_IDLE);
    sub_op   = '0;
    sel_d    = sel_q;
    ser_a_d  = ser_a_q;
    acc_d    = acc_q;
    step_d   = step_q;
    q400_d   = q400_q;
    q100_d   = q100_q;
    q4_d     = q4_q;
    q1_d     = q1_q;
    mon_d    = mon_q;
    r_day_d  = r_day_q;
    r_mon_d  = r_mon_q;
    r_year_d = r_year_q;
    r_dist_d = r_dist_q;
    r_earl_d = r_earl_q;
    r_inv_d  = r_inv_q;
    o_valid_d = m_axis_tready_i ? 1'b0 : o_valid_q;
    o_day_d  = o_day_q;
    o_mon_d  = o_mon_q;
    o_year_d = o_year_q;
    o_dist_d = o_dist_q;
    o_earl_d = o_earl_q;
    o_inv_d  = o_inv_q;

    unique case (state_q)
      S_CHECK: begin
        sel_d    = 1'b0;
        r_day_d  = '0;
        r_mon_d  = '0;
        r_year_d = '0;
        r_dist_d = '0;
        r_earl_d = 1'b0;
        r_inv_d  = chk_bad;
      end
      S_SER_RD: begin
        if (sel_q) begin
          acc_d = NB'(ser);
        end else begin
          ser_a_d = ser;
          if (op_q == OP_ADD) begin
            acc_d  = NB'(ser) + NB'(cnt_q);
            step_d = STEP_W'(Q400B - 1);
            q400_d = '0;
            q100_d = '0;
            q4_d   = '0;
            q1_d   = '0;
            mon_d  = 4'd1;
          end else begin
            sel_d = 1'b1;
          end
        end
      end
      S_CMP: begin
        sub_op = NB'(ser_a_q);
        if (!borrow && (diff[NB-1:0] != '0)) begin
          r_earl_d = 1'b1;
          if (op_q == OP_DIST) begin
            r_dist_d = (|diff[NB-1:DIST_W]) ? '1 : diff[DIST_W-1:0];
          end
        end
      end
      S_Q400: begin
        sub_op = NB'(DAYS_400Y) << step_q;
        if (!borrow) begin
          acc_d          = diff[NB-1:0];
          q400_d[step_q] = 1'b1;
        end
        // the four-year divide reuses the step counter from bit 4
        step_d = (step_q == '0) ? STEP_W'(4) : step_q - STEP_W'(1);
      end
      S_Q100: begin
        sub_op = NB'(DAYS_100Y);
        if (!borrow && (q100_q != 2'd3)) begin
          acc_d  = diff[NB-1:0];
          q100_d = q100_q + 2'd1;
        end
      end
      S_Q4: begin
        sub_op = NB'(DAYS_4Y) << step_q;
        if (!borrow) begin
          acc_d            = diff[NB-1:0];
          q4_d[step_q[2:0]] = 1'b1;
        end
        if (step_q != '0) step_d = step_q - STEP_W'(1);
      end
      S_Q1: begin
        sub_op = NB'(DAYS_1Y);
        if (!borrow && (q1_q != 2'd3)) begin
          acc_d = diff[NB-1:0];
          q1_d  = q1_q + 2'd1;
        end
      end
      S_MON: begin
        sub_op = NB'(mlen);
        if (!borrow && (mon_q != 4'd12)) begin
          acc_d = diff[NB-1:0];
          mon_d = mon_q + 4'd1;
        end
      end
      S_YEAR: begin
        if (year_ext > YMAX) begin
          r_inv_d = 1'b1;
        end else begin
          r_day_d  = acc_q[4:0] + 5'd1;
          r_mon_d  = mon_q;
          r_year_d = year_ext[YEAR_BITS-1:0];
        end
      end
      S_DONE: begin
        if (out_free) begin
          o_valid_d = 1'b1;
          o_day_d   = r_day_q;
          o_mon_d   = r_mon_q;
          o_year_d  = r_year_q;
          o_dist_d  = r_dist_q;
          o_earl_d  = r_earl_q;
          o_inv_d   = r_inv_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      o_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      o_valid_q <= o_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      op_q  <= op_e'(s_axis_tuser_i);
      d1_q  <= s_axis_tdata_i[4:0];
      m1_q  <= s_axis_tdata_i[8:5];
      y1_q  <= s_axis_tdata_i[22:9];
      d2_q  <= s_axis_tdata_i[27:23];
      m2_q  <= s_axis_tdata_i[31:28];
      y2_q  <= s_axis_tdata_i[45:32];
      cnt_q <= s_axis_tdata_i[46 +: COUNT_BITS];
    end
    sel_q    <= sel_d;
    ser_a_q  <= ser_a_d;
    acc_q    <= acc_d;
    step_q   <= step_d;
    q400_q   <= q400_d;
    q100_q   <= q100_d;
    q4_q     <= q4_d;
    q1_q     <= q1_d;
    mon_q    <= mon_d;
    r_day_q  <= r_day_d;
    r_mon_q  <= r_mon_d;
    r_year_q <= r_year_d;
    r_dist_q <= r_dist_d;
    r_earl_q <= r_earl_d;
    r_inv_q  <= r_inv_d;
    o_day_q  <= o_day_d;
    o_mon_q  <= o_mon_d;
    o_year_q <= o_year_d;
    o_dist_q <= o_dist_d;
    o_earl_q <= o_earl_d;
    o_inv_q  <= o_inv_d;
  end

  assign m_axis_tvalid_o = o_valid_q;
  assign m_axis_tdata_o  = OUT_W'({o_earl_q, o_dist_q, o_year_q, o_mon_q, o_day_q});
  assign m_axis_tuser_o  = o_inv_q;

endmodule

// ===== rtl/core/cda_checker.sv =====
// port-level checks for the date arithmetic block, bound to its top level
// depends on cda_pkg and calendar_date_add_and_difference_top
module cda_checker
  import cda_pkg::*;
#(
  parameter  int unsigned YEAR_BITS  = DEF_YEAR_BITS,
  parameter  int unsigned COUNT_BITS = DEF_COUNT_BITS,
  localparam int unsigned IN_W       = ((46 + COUNT_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W      = ((32 + YEAR_BITS + 7) / 8) * 8
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid_i,
  input logic             s_axis_tready_o,
  input logic [IN_W-1:0]  s_axis_tdata_i,
  input logic [1:0]       s_axis_tuser_i,
  input logic             m_axis_tvalid_o,
  input logic             m_axis_tready_i,
  input logic [OUT_W-1:0] m_axis_tdata_o,
  input logic             m_axis_tuser_o
);

  localparam int unsigned DIST_LSB = 9 + YEAR_BITS;
  localparam int unsigned EARL_BIT = DIST_LSB + DIST_W;

  logic [3:0]        out_month;
  logic [4:0]        out_day;
  logic [DIST_W-1:0] out_dist;
  logic              out_earl;
  logic              in_beat;

  assign out_day   = m_axis_tdata_o[4:0];
  assign out_month = m_axis_tdata_o[8:5];
  assign out_dist  = m_axis_tdata_o[DIST_LSB +: DIST_W];
  assign out_earl  = m_axis_tdata_o[EARL_BIT];
  assign in_beat   = s_axis_tvalid_i && s_axis_tready_o && (s_axis_tdata_i != '1 || s_axis_tuser_i != '1 || 1'b1);

  // one item at a time: no beat right after a beat
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !s_axis_tready_o)
    else $error("input taken on two consecutive cycles");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result beat changed");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("invalid result carries data");

  a_dist_needs_earlier: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !out_earl |-> out_dist == '0)
    else $error("distance without earlier flag");

  a_sum_month: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (out_day != 5'd0) |-> (out_month >= 4'd1) && (out_month <= 4'd12))
    else $error("sum date has a bad month");

endmodule

bind calendar_date_add_and_difference_top cda_checker #(
  .YEAR_BITS  (YEAR_BITS),
  .COUNT_BITS (COUNT_BITS)
) u_cda_checker (.*);
